/* src/incremental_pid_gain_scheduled_defines.svh */
// Assertion macros used by the checker file of the PID block
`ifndef INCREMENTAL_PID_GAIN_SCHEDULED_DEFINES_SVH
`define INCREMENTAL_PID_GAIN_SCHEDULED_DEFINES_SVH

// Check a property while out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("pid block check failed");

// Check a property at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("pid block reset check failed");

`endif

/* src/ipgs_pkg.sv */
// Shared constants and types of the gain-scheduled incremental PID block
`timescale 1ns / 1ps

package ipgs_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int REG_CH       = 2;

    localparam int W_MEAS    = 16;
    localparam int W_ERR     = 17;
    localparam int W_DRIVE   = 32;
    localparam int W_CFG     = 48;
    localparam int W_CFG_IDX = 3;
    localparam int W_GAIN    = 16;
    localparam int W_LIM     = 24;
    localparam int W_MUL     = 19;
    localparam int W_PROD    = 2 * W_MUL;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_STOP   = 1'b1;

    typedef enum logic [W_CFG_IDX-1:0] {
        REG_GAINS0  = 3'd0,
        REG_GAINS1  = 3'd1,
        REG_TARGET0 = 3'd2,
        REG_TARGET1 = 3'd3,
        REG_LIMITS0 = 3'd4,
        REG_LIMITS1 = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_MULP,
        S_PSEL,
        S_MULPT,
        S_MULI,
        S_MULD,
        S_WB
    } t_state;

    typedef struct packed {
        logic load;
        logic calc;
        logic mul_p;
        logic psel;
        logic mul_pt;
        logic mul_i;
        logic mul_d;
        logic wb;
    } t_dp_cmd;

    typedef struct packed {
        logic in_sample;
        logic out_full;
    } t_dp_stat;

endpackage

/* src/ipgs_in_if.sv */
// Sample channel: command, channel and measurement with valid/ready
`timescale 1ns / 1ps

interface ipgs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic                                channel;
    logic signed [ipgs_pkg::W_MEAS-1:0]  measurement;

    modport source (output valid, cmd, channel, measurement, input ready);
    modport sink   (input valid, cmd, channel, measurement, output ready);
endinterface

/* src/ipgs_out_if.sv */
// Result channel: drive, error and channel with valid/ready
`timescale 1ns / 1ps

interface ipgs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ipgs_pkg::W_DRIVE-1:0] drive;
    logic signed [ipgs_pkg::W_ERR-1:0]   error;
    logic                                result_channel;

    modport source (output valid, drive, error, result_channel, input ready);
    modport sink   (input valid, drive, error, result_channel, output ready);
endinterface

/* src/ipgs_mul.sv */
// Shared signed multiplier with registered product
`timescale 1ns / 1ps

module ipgs_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [ipgs_pkg::W_MUL-1:0]    i_a,
    input  logic signed [ipgs_pkg::W_MUL-1:0]    i_b,
    output logic signed [ipgs_pkg::W_PROD-1:0]   o_p
);

    logic signed [ipgs_pkg::W_PROD-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

/* src/ipgs_ctrl.sv */
// Sequencer of the PID block: steps one word through the shared datapath
`timescale 1ns / 1ps

module ipgs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ipgs_pkg::t_dp_stat i_stat,
    output ipgs_pkg::t_dp_cmd  o_cmd
);

    ipgs_pkg::t_state r_state;
    ipgs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipgs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipgs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_sample ? ipgs_pkg::S_CALC : ipgs_pkg::S_WB;
                end
            end
            ipgs_pkg::S_CALC:  n_state = ipgs_pkg::S_MULP;
            ipgs_pkg::S_MULP:  n_state = ipgs_pkg::S_PSEL;
            ipgs_pkg::S_PSEL:  n_state = ipgs_pkg::S_MULPT;
            ipgs_pkg::S_MULPT: n_state = ipgs_pkg::S_MULI;
            ipgs_pkg::S_MULI:  n_state = ipgs_pkg::S_MULD;
            ipgs_pkg::S_MULD:  n_state = ipgs_pkg::S_WB;
            ipgs_pkg::S_WB: begin
                if (!i_stat.out_full) begin
                    n_state = ipgs_pkg::S_IDLE;
                end
            end
            default: n_state = ipgs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == ipgs_pkg::S_IDLE);
        o_cmd         = '0;
        o_cmd.load    = (r_state == ipgs_pkg::S_IDLE) && i_in_valid;
        o_cmd.calc    = (r_state == ipgs_pkg::S_CALC);
        o_cmd.mul_p   = (r_state == ipgs_pkg::S_MULP);
        o_cmd.psel    = (r_state == ipgs_pkg::S_PSEL);
        o_cmd.mul_pt  = (r_state == ipgs_pkg::S_MULPT);
        o_cmd.mul_i   = (r_state == ipgs_pkg::S_MULI);
        o_cmd.mul_d   = (r_state == ipgs_pkg::S_MULD);
        o_cmd.wb      = (r_state == ipgs_pkg::S_WB) && !i_stat.out_full;
    end

endmodule

/* src/ipgs_dp.sv */
// Datapath of the PID block: registers, channel state, error terms, accumulation
`timescale 1ns / 1ps

module ipgs_dp #(
    parameter int CHANNELS = ipgs_pkg::CHANNELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ipgs_pkg::W_CFG_IDX-1:0]        i_cfg_idx,
    input  logic [ipgs_pkg::W_CFG-1:0]            i_cfg_data,
    input  ipgs_pkg::t_dp_cmd                     i_cmd,
    output ipgs_pkg::t_dp_stat                    o_stat,
    input  logic                                  i_in_cmd,
    input  logic                                  i_in_channel,
    input  logic signed [ipgs_pkg::W_MEAS-1:0]    i_in_meas,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ipgs_pkg::W_DRIVE-1:0]   o_out_drive,
    output logic signed [ipgs_pkg::W_ERR-1:0]     o_out_error,
    output logic                                  o_out_channel
);

    localparam int NUM_ST = (CHANNELS < ipgs_pkg::REG_CH) ? CHANNELS : ipgs_pkg::REG_CH;
    localparam int W_ACC  = 40;
    localparam int W_M    = ipgs_pkg::W_MUL;
    localparam int W_P    = ipgs_pkg::W_PROD;
    localparam int W_D    = ipgs_pkg::W_DRIVE;
    localparam int W_E    = ipgs_pkg::W_ERR;
    localparam int W_G    = ipgs_pkg::W_GAIN;
    localparam int W_L    = ipgs_pkg::W_LIM;
    localparam int W_MS   = ipgs_pkg::W_MEAS;
    // floor(x / 5) == (x * 52429) >> 18 for every x below 2^18
    localparam logic signed [W_M-1:0] RECIP5 = 19'sd52429;
    localparam int                    P_LSB  = 18;
    localparam logic [W_E-1:0]        NEAR_BAND = 17'd50;
    localparam logic [W_E-1:0]        POM_BAND  = 17'd300;
    localparam logic signed [W_ACC-1:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [W_ACC-1:0] SAT_LO = -40'sd2147483648;

    function automatic logic signed [W_D-1:0] f_sat32(input logic signed [W_ACC-1:0] v);
        logic signed [W_D-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[W_D-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[W_D-1:0];
        end else begin
            r = v[W_D-1:0];
        end
        return r;
    endfunction

    // configuration registers
    logic [ipgs_pkg::W_CFG-1:0]  r_gains  [ipgs_pkg::REG_CH];
    logic signed [W_MS-1:0]      r_target [ipgs_pkg::REG_CH];
    logic [ipgs_pkg::W_CFG-1:0]  r_limits [ipgs_pkg::REG_CH];
    logic                        w_lim_ok;

    assign w_lim_ok = $signed(i_cfg_data[W_L-1:0]) <= $signed(i_cfg_data[2*W_L-1:W_L]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < ipgs_pkg::REG_CH; c++) begin
                r_gains[c]  <= '0;
                r_target[c] <= '0;
                r_limits[c] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (ipgs_pkg::t_reg_idx'(i_cfg_idx))
                ipgs_pkg::REG_GAINS0:  r_gains[0]  <= i_cfg_data;
                ipgs_pkg::REG_GAINS1:  r_gains[1]  <= i_cfg_data;
                ipgs_pkg::REG_TARGET0: r_target[0] <= i_cfg_data[W_MS-1:0];
                ipgs_pkg::REG_TARGET1: r_target[1] <= i_cfg_data[W_MS-1:0];
                ipgs_pkg::REG_LIMITS0: begin
                    if (w_lim_ok) begin
                        r_limits[0] <= i_cfg_data;
                    end
                end
                ipgs_pkg::REG_LIMITS1: begin
                    if (w_lim_ok) begin
                        r_limits[1] <= i_cfg_data;
                    end
                end
                default: ;
            endcase
        end
    end

    // captured word
    logic                   r_stop;
    logic                   r_ch;
    logic                   r_valid_ch;
    logic signed [W_MS-1:0] r_meas;
    logic                   w_in_valid_ch;

    assign w_in_valid_ch = ({31'd0, i_in_channel} < 32'(NUM_ST));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stop     <= (i_in_cmd == ipgs_pkg::CMD_STOP);
            r_ch       <= i_in_channel;
            r_meas     <= i_in_meas;
            r_valid_ch <= w_in_valid_ch;
        end
    end

    // per-channel state; the error two samples back is the stored previous error
    logic signed [W_E-1:0]  r_err_now   [NUM_ST];
    logic signed [W_E-1:0]  r_err_prev  [NUM_ST];
    logic signed [W_MS-1:0] r_last      [NUM_ST];
    logic signed [W_D-1:0]  r_drive     [NUM_ST];
    logic signed [W_D-1:0]  r_pom       [NUM_ST];

    logic signed [W_E-1:0]  s_err_now;
    logic signed [W_E-1:0]  s_err_prev;
    logic signed [W_MS-1:0] s_last;
    logic signed [W_D-1:0]  s_drive;
    logic signed [W_D-1:0]  s_pom;

    always_comb begin
        s_err_now  = '0;
        s_err_prev = '0;
        s_last     = '0;
        s_drive    = '0;
        s_pom      = '0;
        for (int g = 0; g < NUM_ST; g++) begin
            if (r_ch == 1'(g)) begin
                s_err_now  = r_err_now[g];
                s_err_prev = r_err_prev[g];
                s_last     = r_last[g];
                s_drive    = r_drive[g];
                s_pom      = r_pom[g];
            end
        end
    end

    // selected configuration
    logic [ipgs_pkg::W_CFG-1:0] w_gains;
    logic [ipgs_pkg::W_CFG-1:0] w_limits;
    logic signed [W_MS-1:0]     w_target;
    logic [W_G-1:0]             w_kp;
    logic [W_G-1:0]             w_ki;
    logic [W_G-1:0]             w_kd;

    assign w_gains  = r_gains[r_ch];
    assign w_limits = r_limits[r_ch];
    assign w_target = r_target[r_ch];
    assign w_kp     = w_gains[W_G-1:0];
    assign w_ki     = w_gains[2*W_G-1:W_G];
    assign w_kd     = w_gains[3*W_G-1:2*W_G];

    // error terms and limit tests
    logic signed [W_E-1:0]   w_e;
    logic signed [W_E:0]     w_pe;
    logic signed [W_E+1:0]   w_de;
    logic signed [W_E-1:0]   w_dm;
    logic [W_E-1:0]          w_ae;
    logic signed [W_D-1:0]   w_hi;
    logic signed [W_D-1:0]   w_lo;
    logic                    w_above;
    logic                    w_below;
    logic                    w_ie_ok;
    logic                    w_usepom;
    logic [W_G+1:0]          w_kp3;

    assign w_e     = {w_target[W_MS-1], w_target} - {r_meas[W_MS-1], r_meas};
    assign w_pe    = {w_e[W_E-1], w_e} - {s_err_now[W_E-1], s_err_now};
    assign w_de    = {{2{w_e[W_E-1]}}, w_e} - {s_err_now[W_E-1], s_err_now, 1'b0}
                   + {{2{s_err_prev[W_E-1]}}, s_err_prev};
    assign w_dm    = {r_meas[W_MS-1], r_meas} - {s_last[W_MS-1], s_last};
    assign w_ae    = w_e[W_E-1] ? (17'd0 - w_e) : w_e;
    assign w_hi    = {w_limits[2*W_L-1:W_L], 8'd0};
    assign w_lo    = {w_limits[W_L-1:0], 8'd0};
    assign w_above = s_drive > w_hi;
    assign w_below = !w_above && (s_drive < w_lo);
    assign w_ie_ok = !(w_above || w_below)
                   || (w_above && (w_e[W_E-1] || (w_e == '0)))
                   || (w_below && !w_e[W_E-1]);
    assign w_usepom = (w_above || w_below) && (w_ae < POM_BAND);
    assign w_kp3   = {2'b00, w_kp} + {1'b0, w_kp, 1'b0};

    logic signed [W_E-1:0]   r_e;
    logic signed [W_E:0]     r_pe;
    logic signed [W_E+1:0]   r_de;
    logic signed [W_E-1:0]   r_dm;
    logic signed [W_E-1:0]   r_ie;
    logic                    r_near;
    logic                    r_usepom;
    logic [W_G+1:0]          r_kp3;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_e      <= w_e;
            r_pe     <= w_pe;
            r_de     <= w_de;
            r_dm     <= w_dm;
            r_ie     <= w_ie_ok ? w_e : '0;
            r_near   <= (w_ae <= NEAR_BAND);
            r_usepom <= w_usepom;
            r_kp3    <= w_kp3;
        end
    end

    // shared multiplier
    logic signed [W_M-1:0]   w_ma;
    logic signed [W_M-1:0]   w_mb;
    logic                    w_mul_en;
    logic signed [W_P-1:0]   w_prod;
    logic [W_G-1:0]          r_p;
    logic [W_G-1:0]          w_ki_s;
    logic [W_G-1:0]          w_kd_s;

    assign w_ki_s   = r_near ? {1'b0, w_ki[W_G-1:1]} : w_ki;
    assign w_kd_s   = r_near ? {1'b0, w_kd[W_G-1:1]} : w_kd;
    assign w_mul_en = i_cmd.mul_p || i_cmd.mul_pt || i_cmd.mul_i || i_cmd.mul_d;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        priority if (i_cmd.mul_p) begin
            w_ma = {1'b0, r_kp3};
            w_mb = RECIP5;
        end else if (i_cmd.mul_pt) begin
            w_ma = {3'b000, r_p};
            w_mb = r_usepom ? {{2{r_dm[W_E-1]}}, r_dm} : {r_pe[W_E], r_pe};
        end else if (i_cmd.mul_i) begin
            w_ma = {3'b000, w_ki_s};
            w_mb = {{2{r_ie[W_E-1]}}, r_ie};
        end else if (i_cmd.mul_d) begin
            w_ma = {3'b000, w_kd_s};
            w_mb = r_de;
        end else begin
            w_ma = '0;
            w_mb = '0;
        end
    end

    ipgs_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.psel) begin
            r_p <= r_near ? w_prod[P_LSB+W_G-1:P_LSB] : w_kp;
        end
    end

    // accumulation
    logic signed [W_ACC-1:0] w_prod40;
    logic signed [W_ACC-1:0] w_pom40;
    logic signed [W_D-1:0]   w_pom_new;
    logic signed [W_D-1:0]   w_drive_new;
    logic signed [W_D-1:0]   r_pom_new;
    logic signed [W_ACC-1:0] r_pterm;
    logic signed [W_ACC-1:0] r_acc;

    assign w_prod40    = {{(W_ACC-W_P){w_prod[W_P-1]}}, w_prod};
    assign w_pom40     = {{(W_ACC-W_D){s_pom[W_D-1]}}, s_pom};
    assign w_pom_new   = f_sat32(w_pom40 - w_prod40);
    assign w_drive_new = f_sat32(r_acc + w_prod40);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_i) begin
            r_pom_new <= r_usepom ? w_pom_new : '0;
            r_pterm   <= r_usepom ? {{(W_ACC-W_D){w_pom_new[W_D-1]}}, w_pom_new} : w_prod40;
        end
        if (i_cmd.mul_d) begin
            r_acc <= {{(W_ACC-W_D){s_drive[W_D-1]}}, s_drive} + r_pterm + w_prod40;
        end
    end

    // state write-back
    for (genvar g = 0; g < NUM_ST; g++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_err_now[g]   <= '0;
                r_err_prev[g]  <= '0;
                r_last[g]      <= '0;
                r_drive[g]     <= '0;
                r_pom[g]       <= '0;
            end else if (i_cmd.wb && r_valid_ch && (r_ch == 1'(g))) begin
                if (r_stop) begin
                    r_err_now[g]   <= '0;
                    r_err_prev[g]  <= '0;
                    r_last[g]      <= '0;
                    r_drive[g]     <= '0;
                    r_pom[g]       <= '0;
                end else begin
                    r_err_prev[g]  <= r_err_now[g];
                    r_err_now[g]   <= r_e;
                    r_last[g]      <= r_meas;
                    r_drive[g]     <= w_drive_new;
                    r_pom[g]       <= r_pom_new;
                end
            end
        end
    end

    // output register
    logic                  r_out_valid;
    logic signed [W_D-1:0] r_out_drive;
    logic signed [W_E-1:0] r_out_error;
    logic                  r_out_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wb) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_out_drive <= (r_valid_ch && !r_stop) ? w_drive_new : '0;
            r_out_error <= (r_valid_ch && !r_stop) ? r_e : '0;
            r_out_ch    <= r_ch;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_drive   = r_out_drive;
    assign o_out_error   = r_out_error;
    assign o_out_channel = r_out_ch;

    assign o_stat.in_sample = (i_in_cmd == ipgs_pkg::CMD_SAMPLE) && w_in_valid_ch;
    assign o_stat.out_full  = r_out_valid && !i_out_ready;

endmodule

/* src/incremental_pid_gain_scheduled.sv */
// Top level of the two-channel gain-scheduled incremental PID controller
// Usage:
//   i_in carries one word per sample: cmd (sample or stop), channel and a
//   signed measurement. o_out returns exactly one word per input word:
//   the saturated Q23.8 drive, the error and the channel it belongs to.
//   Gains, setpoints and output limits are written through i_cfg_we,
//   i_cfg_idx and i_cfg_data; the user must write them only while the
//   block is idle (not enforced); a min-above-max limits write is dropped.
// Sequence:
//   A control sample steps through the calc, P-gain multiply, P-select,
//   P, I and D multiply and write-back states; its result is registered
//   at write-back. A stop word, or a word for a channel that is not built,
//   goes straight to write-back. The single shared multiplier forms the
//   scaled P gain and the P, I and D products one after another.
// Reset:
//   Synchronous reset clears all gains, setpoints, limits and channel state;
//   the block comes up ready with no result pending.
// Backpressure:
//   A finished result sits in the output register; the next word is taken
//   meanwhile, and the block holds at write-back until the register frees.
`timescale 1ns / 1ps

module incremental_pid_gain_scheduled #(
    parameter int CHANNELS = ipgs_pkg::CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ipgs_pkg::W_CFG_IDX-1:0]     i_cfg_idx,
    input  logic [ipgs_pkg::W_CFG-1:0]         i_cfg_data,
    ipgs_in_if.sink                            i_in,
    ipgs_out_if.source                         o_out
);

    ipgs_pkg::t_dp_cmd  w_cmd;
    ipgs_pkg::t_dp_stat w_stat;

    // sequencer: owns input ready and paces the datapath
    ipgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: registers, channel state, shared multiplier, output register
    ipgs_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_cmd      (i_in.cmd),
        .i_in_channel  (i_in.channel),
        .i_in_meas     (i_in.measurement),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_drive   (o_out.drive),
        .o_out_error   (o_out.error),
        .o_out_channel (o_out.result_channel)
    );

endmodule

/* src/ipgs_chk.sv */
// Port-level checks of the PID block and their binding to the top level
`timescale 1ns / 1ps
`include "incremental_pid_gain_scheduled_defines.svh"

module ipgs_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic signed [ipgs_pkg::W_DRIVE-1:0]  i_out_drive,
    input logic signed [ipgs_pkg::W_ERR-1:0]    i_out_error,
    input logic                                 i_out_channel
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_out_stall;
    logic [ipgs_pkg::W_DRIVE+ipgs_pkg::W_ERR:0] w_out_word;
    logic [1:0] r_pend;
    logic [1:0] n_pend;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_out_acc   = i_out_valid && i_out_ready;
    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_out_word  = {i_out_drive, i_out_error, i_out_channel};

    // count words taken but not yet delivered
    always_comb begin
        n_pend = r_pend;
        if (w_in_acc && !w_out_acc) begin
            n_pend = r_pend + 2'd1;
        end else if (!w_in_acc && w_out_acc) begin
            n_pend = r_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready)
    `ASSERT_PROP(a_one_in_flight, i_clk, i_rst_n, w_in_acc |=> !i_in_ready)
    `ASSERT_PROP(a_stall_hold, i_clk, i_rst_n, w_out_stall |=> i_out_valid && $stable(w_out_word))
    `ASSERT_PROP(a_no_spurious, i_clk, i_rst_n, i_out_valid |-> r_pend != 2'd0)
    `ASSERT_PROP(a_error_range, i_clk, i_rst_n, i_out_valid |-> i_out_error != 17'h10000)

endmodule

bind incremental_pid_gain_scheduled ipgs_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_drive   (o_out.drive),
    .i_out_error   (o_out.error),
    .i_out_channel (o_out.result_channel)
);
